FILE: design/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Types and constants of the mesh volume and area accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mva_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int DOT_W = 64;
  localparam int SQ_W = 72;
  localparam int ROOT_W = 36;
  localparam int ROOT_CW = 6;
  localparam int STEP_CW = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic root_step;
    logic accumulate;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic root_done;
  } status_t;

  typedef struct packed {
    logic signed [15:0] p0_x;
    logic signed [15:0] p0_y;
    logic signed [15:0] p0_z;
    logic signed [15:0] p1_x;
    logic signed [15:0] p1_y;
    logic signed [15:0] p1_z;
    logic signed [15:0] p2_x;
    logic signed [15:0] p2_y;
    logic signed [15:0] p2_z;
    logic final_tri;
  } tri_t;

  typedef struct packed {
    logic signed [63:0] six_volume;
    logic [62:0] double_area;
    logic overflowed;
  } sums_t;

endpackage

`default_nettype wire

FILE: design/mva_if.sv
// ----------------------------------------------------------------------------
// mva_tri_if / mva_sums_if
// Valid-ready channels for triangle requests and mesh results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mva_tri_if;
  logic valid;
  logic ready;
  mva_pkg::tri_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mva_sums_if;
  logic valid;
  logic ready;
  mva_pkg::sums_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/mva_datapath.sv
// ----------------------------------------------------------------------------
// mva_datapath
// Shared multiplier, bit-serial square root and saturating accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mva_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire mva_pkg::tri_t tri_in,
  input  wire mva_pkg::cmd_t cmd,
  output mva_pkg::status_t status,
  output mva_pkg::sums_t sums
);

  localparam int CW = mva_pkg::COORD_WIDTH;
  localparam int DW = mva_pkg::DIFF_W;
  localparam int XW = mva_pkg::CROSS_W;
  localparam int RW = mva_pkg::ROOT_W;
  localparam int SW = mva_pkg::SQ_W;
  localparam logic [62:0] AREA_MAX = '1;
  localparam logic [3:0] LAST_STEP = 4'd12;

  logic signed [CW-1:0] a [3];
  logic signed [DW-1:0] b [3];
  logic signed [DW-1:0] c [3];
  logic signed [XW-1:0] r [3];
  logic signed [mva_pkg::DOT_W-1:0] dot;
  logic [SW-1:0] sq;
  logic [mva_pkg::STEP_CW-1:0] step;
  logic signed [XW-1:0] op_a;
  logic signed [XW-1:0] op_b;
  logic signed [2*XW-1:0] prod;
  logic signed [2*XW-1:0] prod_q;
  logic [RW-1:0] root;
  logic [RW:0] rem;
  logic [SW-1:0] src;
  logic [mva_pkg::ROOT_CW-1:0] rbit;
  logic signed [63:0] vsum;
  logic [62:0] asum;
  logic sat;

  // Multiply schedule: six cross terms, three squares, three dot terms.
  // A product is registered in prod_q and folded in at the next step.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      4'd0: begin op_a = XW'(b[1]); op_b = XW'(c[2]); end
      4'd1: begin op_a = XW'(b[2]); op_b = XW'(c[1]); end
      4'd2: begin op_a = XW'(b[2]); op_b = XW'(c[0]); end
      4'd3: begin op_a = XW'(b[0]); op_b = XW'(c[2]); end
      4'd4: begin op_a = XW'(b[0]); op_b = XW'(c[1]); end
      4'd5: begin op_a = XW'(b[1]); op_b = XW'(c[0]); end
      4'd6: begin op_a = r[0]; op_b = r[0]; end
      4'd7: begin op_a = r[1]; op_b = r[1]; end
      4'd8: begin op_a = r[2]; op_b = r[2]; end
      4'd9: begin op_a = XW'(a[0]); op_b = r[0]; end
      4'd10: begin op_a = XW'(a[1]); op_b = r[1]; end
      4'd11: begin op_a = XW'(a[2]); op_b = r[2]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end
  assign prod = op_a * op_b;

  // Digit-by-digit square root: two bits of the squared magnitude enter the
  // remainder per step and one root bit is decided by a compare and subtract.
  logic [RW+2:0] rem_sh;
  logic [RW+2:0] sub_try;
  logic [RW+2:0] rem_diff;
  assign rem_sh = {rem, src[SW-1 -: 2]};
  assign sub_try = {1'b0, root, 2'b01};
  assign rem_diff = rem_sh - sub_try;

  logic signed [64:0] vwide;
  logic [63:0] awide;
  assign vwide = 65'(vsum) + 65'(dot);
  assign awide = 64'(asum) + 64'(root);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a[0] <= tri_in.p0_x[CW-1:0];
      a[1] <= tri_in.p0_y[CW-1:0];
      a[2] <= tri_in.p0_z[CW-1:0];
      b[0] <= DW'(signed'(tri_in.p1_x[CW-1:0])) - DW'(signed'(tri_in.p0_x[CW-1:0]));
      b[1] <= DW'(signed'(tri_in.p1_y[CW-1:0])) - DW'(signed'(tri_in.p0_y[CW-1:0]));
      b[2] <= DW'(signed'(tri_in.p1_z[CW-1:0])) - DW'(signed'(tri_in.p0_z[CW-1:0]));
      c[0] <= DW'(signed'(tri_in.p2_x[CW-1:0])) - DW'(signed'(tri_in.p0_x[CW-1:0]));
      c[1] <= DW'(signed'(tri_in.p2_y[CW-1:0])) - DW'(signed'(tri_in.p0_y[CW-1:0]));
      c[2] <= DW'(signed'(tri_in.p2_z[CW-1:0])) - DW'(signed'(tri_in.p0_z[CW-1:0]));
      dot <= '0;
      sq <= '0;
      root <= '0;
      rem <= '0;
      rbit <= mva_pkg::ROOT_CW'(RW - 1);
    end
    if (cmd.mul_step) begin
      prod_q <= prod;
      // Fold the product registered in the previous step.
      unique case (step)
        4'd1: r[0] <= XW'(prod_q);
        4'd2: r[0] <= r[0] - XW'(prod_q);
        4'd3: r[1] <= XW'(prod_q);
        4'd4: r[1] <= r[1] - XW'(prod_q);
        4'd5: r[2] <= XW'(prod_q);
        4'd6: r[2] <= r[2] - XW'(prod_q);
        4'd7, 4'd8, 4'd9: sq <= sq + SW'(unsigned'(prod_q));
        4'd10, 4'd11, 4'd12: dot <= dot + 64'(prod_q);
        default: ;
      endcase
      // The squared magnitude is complete by now; hand it to the root.
      if (step == LAST_STEP) src <= sq;
    end
    if (cmd.root_step) begin
      src <= src << 2;
      if (rem_sh >= sub_try) begin
        rem <= rem_diff[RW:0];
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[RW:0];
        root <= {root[RW-2:0], 1'b0};
      end
      rbit <= rbit - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.load) begin
      step <= '0;
    end else if (cmd.mul_step) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vsum <= '0;
      asum <= '0;
      sat <= 1'b0;
    end else if (cmd.accumulate) begin
      if (vwide[64] != vwide[63]) begin
        vsum <= vwide[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        sat <= 1'b1;
      end else begin
        vsum <= vwide[63:0];
      end
      if (awide[63]) begin
        asum <= AREA_MAX;
        sat <= 1'b1;
      end else begin
        asum <= awide[62:0];
      end
    end
  end

  assign status.mul_done = (step == LAST_STEP + 1'b1);
  assign status.root_done = (rbit == '0);
  assign sums.six_volume = vsum;
  assign sums.double_area = asum;
  assign sums.overflowed = sat;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_acc_not_in_mul, cmd.accumulate, !cmd.mul_step, "accumulate during multiply")
  `ASSERT_NEXT(a_clear_zero, cmd.clear && !cmd.accumulate, vsum == '0 && asum == '0 && !sat,
               "sums not cleared")
  `ASSERT_IMPL(a_root_le, cmd.accumulate, 72'(root) * 72'(root) <= sq, "root too large")

endmodule

`default_nettype wire

FILE: design/mva_ctrl.sv
// ----------------------------------------------------------------------------
// mva_ctrl
// Sequencer for one triangle: load, multiply, root, accumulate and, on the final triangle, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mva_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_final,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire mva_pkg::status_t status,
  output mva_pkg::cmd_t cmd
);

  mva_pkg::state_t state, state_next;
  logic fin, fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mva_pkg::ST_IDLE;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
    end
  end

  always_comb begin
    state_next = state;
    fin_next = fin;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      mva_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          fin_next = in_final;
          state_next = mva_pkg::ST_MUL;
        end
      end
      mva_pkg::ST_MUL: begin
        if (status.mul_done) state_next = mva_pkg::ST_ROOT;
        else cmd.mul_step = 1'b1;
      end
      mva_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_done) state_next = mva_pkg::ST_ACC;
      end
      mva_pkg::ST_ACC: begin
        cmd.accumulate = 1'b1;
        state_next = fin ? mva_pkg::ST_OUT : mva_pkg::ST_IDLE;
      end
      mva_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_next = mva_pkg::ST_IDLE;
        end
      end
      default: state_next = mva_pkg::ST_IDLE;
    endcase
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_load_idle, cmd.load, state == mva_pkg::ST_IDLE, "load outside idle")
  `ASSERT_NEXT(a_acc_leaves, state == mva_pkg::ST_ACC,
               state == mva_pkg::ST_OUT || state == mva_pkg::ST_IDLE, "stuck after accumulate")
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while waiting")

endmodule

`default_nettype wire

FILE: design/mesh_volume_area_accumulator.sv
// ----------------------------------------------------------------------------
// mesh_volume_area_accumulator
// Sums six times volume and twice area over the triangles of a mesh.
// ----------------------------------------------------------------------------
// Each request is loaded, then runs on the single shared multiplier
// (twelve products for cross product, squared magnitude and dot product,
// then a fold of the last product and a hand-over to the root), then
// through the bit-serial square root, and is accumulated; a final request
// then holds its result until it is taken. Sums saturate and set overflowed.
`timescale 1ns / 1ps
`default_nettype none

module mesh_volume_area_accumulator (
  input  wire logic clk,
  input  wire logic rst,
  mva_tri_if.sink tri_in,
  mva_sums_if.source sums_out
);

  mva_pkg::cmd_t cmd;
  mva_pkg::status_t status;

  mva_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(tri_in.valid),
    .in_final(tri_in.data.final_tri),
    .in_ready(tri_in.ready),
    .out_valid(sums_out.valid),
    .out_ready(sums_out.ready),
    .status(status),
    .cmd(cmd)
  );

  mva_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .tri_in(tri_in.data),
    .cmd(cmd),
    .status(status),
    .sums(sums_out.data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/mesh_sums_checker.sv
// ----------------------------------------------------------------------------
// mesh_sums_checker
// Watches the triangle and result channels and predicts the mesh sums.
// Each accepted result is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mesh_sums_checker (
  input logic clk,
  input logic rst,
  mva_tri_if tri_mon,
  mva_sums_if sums_mon,
  output int fail_count,
  output int pending
);
  import mva_pkg::*;

  localparam logic signed [65:0] VOL_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] VOL_MIN = -66'sh0_8000_0000_0000_0000;
  localparam logic [63:0] AREA_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic signed [63:0] volume_acc;
  logic [62:0] area_acc;
  logic sat_seen;
  sums_t expected_sums[$];

  assign pending = expected_sums.size();

  // Adds one triangle to the running sums; on the last triangle of a mesh
  // the sums are queued as the expected result and cleared.
  task automatic add_triangle(input tri_t t);
    longint a[3], b[3], c[3], r[3];
    longint dot;
    logic [71:0] sq, mag, cand_sq;
    logic [35:0] root, cand;
    logic signed [65:0] new_vol;
    logic [63:0] new_area;
    sums_t s;
    a[0] = $signed(t.p0_x); a[1] = $signed(t.p0_y); a[2] = $signed(t.p0_z);
    b[0] = longint'($signed(t.p1_x)) - a[0];
    b[1] = longint'($signed(t.p1_y)) - a[1];
    b[2] = longint'($signed(t.p1_z)) - a[2];
    c[0] = longint'($signed(t.p2_x)) - a[0];
    c[1] = longint'($signed(t.p2_y)) - a[1];
    c[2] = longint'($signed(t.p2_z)) - a[2];
    r[0] = b[1] * c[2] - b[2] * c[1];
    r[1] = b[2] * c[0] - b[0] * c[2];
    r[2] = b[0] * c[1] - b[1] * c[0];
    dot = a[0] * r[0] + a[1] * r[1] + a[2] * r[2];
    sq = '0;
    for (int k = 0; k < 3; k++) begin
      mag = 72'(r[k] < 0 ? -r[k] : r[k]);
      sq = sq + mag * mag;
    end
    root = '0;
    for (int i = 35; i >= 0; i--) begin
      cand = root | (36'd1 << i);
      cand_sq = 72'(cand) * 72'(cand);
      if (cand_sq <= sq) root = cand;
    end
    new_vol = 66'(volume_acc) + 66'(dot);
    if (new_vol > VOL_MAX) begin
      volume_acc = VOL_MAX[63:0];
      sat_seen = 1'b1;
    end else if (new_vol < VOL_MIN) begin
      volume_acc = VOL_MIN[63:0];
      sat_seen = 1'b1;
    end else begin
      volume_acc = new_vol[63:0];
    end
    new_area = 64'(area_acc) + 64'(root);
    if (new_area > AREA_MAX) begin
      area_acc = AREA_MAX[62:0];
      sat_seen = 1'b1;
    end else begin
      area_acc = new_area[62:0];
    end
    if (t.final_tri) begin
      s.six_volume = volume_acc;
      s.double_area = area_acc;
      s.overflowed = sat_seen;
      expected_sums.push_back(s);
      volume_acc = '0;
      area_acc = '0;
      sat_seen = 1'b0;
    end
  endtask

  initial begin
    fail_count = 0;
    volume_acc = '0;
    area_acc = '0;
    sat_seen = 1'b0;
  end

  always @(posedge clk) begin
    sums_t exp_s;
    if (!rst) begin
      if (tri_mon.valid && tri_mon.ready) add_triangle(tri_mon.data);
      if (sums_mon.valid && sums_mon.ready) begin
        if (expected_sums.size() == 0) begin
          $error("result with no mesh pending: %p", sums_mon.data);
          fail_count++;
        end else begin
          exp_s = expected_sums.pop_front();
          if (sums_mon.data.six_volume !== exp_s.six_volume) begin
            $error("six_volume expected %0d actual %0d", exp_s.six_volume,
                   $signed(sums_mon.data.six_volume));
            fail_count++;
          end
          if (sums_mon.data.double_area !== exp_s.double_area) begin
            $error("double_area expected %0d actual %0d", exp_s.double_area,
                   sums_mon.data.double_area);
            fail_count++;
          end
          if (sums_mon.data.overflowed !== exp_s.overflowed) begin
            $error("overflowed expected %0b actual %0b", exp_s.overflowed,
                   sums_mon.data.overflowed);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_mesh_volume_area_accumulator.sv
// ----------------------------------------------------------------------------
// tb_mesh_volume_area_accumulator
// Drives triangle requests into the accumulator with random idling on both
// channels: directed corner triangles first, then random meshes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mesh_volume_area_accumulator;
  import mva_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 120;
  localparam int NUM_TRIS = 1150;

  logic clk;
  logic rst;
  int fail_count;
  int pending;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int tri_count;

  mva_tri_if tri_ch ();
  mva_sums_if sums_ch ();

  mesh_volume_area_accumulator DUT (
    .clk(clk),
    .rst(rst),
    .tri_in(tri_ch),
    .sums_out(sums_ch)
  );

  mesh_sums_checker checker_i (
    .clk(clk),
    .rst(rst),
    .tri_mon(tri_ch),
    .sums_mon(sums_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side stalls at random according to the current phase.
  initial begin
    sums_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      sums_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [15:0] rand_coord(int span);
    if (span >= 32768) return 16'($urandom);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic tri_t random_tri(int span, logic last);
    tri_t t;
    t.p0_x = rand_coord(span); t.p0_y = rand_coord(span); t.p0_z = rand_coord(span);
    t.p1_x = rand_coord(span); t.p1_y = rand_coord(span); t.p1_z = rand_coord(span);
    t.p2_x = rand_coord(span); t.p2_y = rand_coord(span); t.p2_z = rand_coord(span);
    t.final_tri = last;
    return t;
  endfunction

  function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz, logic last);
    tri_t t;
    t.p0_x = 16'(ax); t.p0_y = 16'(ay); t.p0_z = 16'(az);
    t.p1_x = 16'(bx); t.p1_y = 16'(by); t.p1_z = 16'(bz);
    t.p2_x = 16'(cx); t.p2_y = 16'(cy); t.p2_z = 16'(cz);
    t.final_tri = last;
    return t;
  endfunction

  // Presents one request at the falling edge and holds it until accepted.
  task automatic send_tri(input tri_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tri_ch.valid = 1'b0;
      @(negedge clk);
    end
    tri_ch.data = t;
    tri_ch.valid = 1'b1;
    @(posedge clk);
    while (!tri_ch.ready) @(posedge clk);
    tri_count++;
    @(negedge clk);
    tri_ch.valid = 1'b0;
  endtask

  initial begin
    int mesh_len, span, waited;
    rst = 1'b1;
    tri_ch.valid = 1'b0;
    tri_ch.data = '0;
    send_idle_pct = 7;
    recv_idle_pct = 57;
    tri_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Degenerate triangles, extremes and a closed tetrahedron.
    send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_tri(make_tri(5, 5, 5, 5, 5, 5, 9, 9, 9, 1'b1));
    send_tri(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                      -32768, 32767, 32767, 1'b0));
    send_tri(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                      32767, -32768, -32768, 1'b1));
    send_tri(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                      32767, 32767, -32768, 1'b1));
    send_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1));
    send_tri(make_tri(0, 0, 0, 10, 0, 0, 0, 10, 0, 1'b0));
    send_tri(make_tri(0, 0, 0, 0, 0, 10, 10, 0, 0, 1'b0));
    send_tri(make_tri(0, 0, 0, 0, 10, 0, 0, 0, 10, 1'b0));
    send_tri(make_tri(10, 0, 0, 0, 0, 10, 0, 10, 0, 1'b1));
    // A 10-by-10 square quad sent as two triangles, off the origin.
    send_tri(make_tri(3, 4, 7, 13, 4, 7, 13, 14, 7, 1'b0));
    send_tri(make_tri(3, 4, 7, 13, 14, 7, 3, 14, 7, 1'b1));
    send_tri(random_tri(32768, 1'b0));
    send_tri(random_tri(32768, 1'b1));

    while (tri_count < NUM_TRIS) begin
      if (tri_count > NUM_TRIS / 3 && tri_count <= 2 * NUM_TRIS / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 7;
      end else if (tri_count > 2 * NUM_TRIS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mesh_len = $urandom_range(1, 8);
      case ($urandom_range(3))
        0: span = 32768;
        1: span = 200;
        default: span = 4000;
      endcase
      for (int i = 0; i < mesh_len; i++)
        send_tri(random_tri(span, i == mesh_len - 1));
    end

    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: mesh_volume_area_accumulator.f
+incdir+design
design/mva_pkg.sv
design/mva_if.sv
design/mva_datapath.sv
design/mva_ctrl.sv
design/mesh_volume_area_accumulator.sv
tb/sv/mesh_sums_checker.sv
tb/sv/tb_mesh_volume_area_accumulator.sv
